>>> rtl/core/shs_pkg.sv
// Shared types, constants and the ratio table of the segregation happiness stencil.
`default_nettype none

package shs_pkg;

  // Grid geometry. The line store depth follows the top-level parameter.
  localparam int GRID_WIDTH_DEFAULT = 32;
  localparam int GRID_HEIGHT        = 32;
  localparam int WIN_COLS           = 3;

  // Field widths.
  localparam int CELL_W     = 2;
  localparam int ROW_W      = 5;
  localparam int COL_W      = 5;
  localparam int SIZE_W     = 6;
  localparam int THR_W      = 9;
  localparam int COUNT_W    = 4;
  localparam int RATIO_W    = 9;
  localparam int TOTAL_W    = 11;
  localparam int SUM_W      = 19;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  // Cell codes.
  localparam logic [CELL_W-1:0] CELL_EMPTY  = 2'd0;
  localparam logic [CELL_W-1:0] CELL_FIRST  = 2'd1;
  localparam logic [CELL_W-1:0] CELL_SECOND = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS      = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [THR_W-1:0]  THRESHOLD_RESET = 9'd128;
  localparam logic [SIZE_W-1:0] COLS_RESET      = 6'd32;
  localparam logic [SIZE_W-1:0] ROWS_RESET      = 6'd32;

  typedef logic [CELL_W-1:0] cell_t;

  // One column of the 3x3 window: the row above, the middle row and the row below.
  typedef struct packed {
    cell_t top;
    cell_t mid;
    cell_t bot;
  } column_t;

  // Control that travels with a window step: which neighbors count and where the
  // centre cell sits.
  typedef struct packed {
    logic             emit;
    logic             last;
    logic             top_ok;
    logic             bot_ok;
    logic             left_ok;
    logic             right_ok;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } step_ctrl_t;

  typedef struct packed {
    logic [ROW_W-1:0]   cell_row;
    logic [COL_W-1:0]   cell_col;
    logic               occupied;
    logic               happy;
    logic [COUNT_W-1:0] own_count;
    logic [COUNT_W-1:0] other_count;
    logic [RATIO_W-1:0] ratio_q8;
    logic               frame_last;
    logic [TOTAL_W-1:0] happy_total;
    logic [TOTAL_W-1:0] unhappy_total;
    logic [SUM_W-1:0]   ratio_sum;
  } result_t;

  // floor(own * 256 / total), indexed [total][own]. Row zero is unused.
  localparam logic [RATIO_W-1:0] RATIO_LUT [9][9] = '{
    '{9'd0, 9'd0,   9'd0,   9'd0,   9'd0,   9'd0,   9'd0,   9'd0,   9'd0  },
    '{9'd0, 9'd256, 9'd0,   9'd0,   9'd0,   9'd0,   9'd0,   9'd0,   9'd0  },
    '{9'd0, 9'd128, 9'd256, 9'd0,   9'd0,   9'd0,   9'd0,   9'd0,   9'd0  },
    '{9'd0, 9'd85,  9'd170, 9'd256, 9'd0,   9'd0,   9'd0,   9'd0,   9'd0  },
    '{9'd0, 9'd64,  9'd128, 9'd192, 9'd256, 9'd0,   9'd0,   9'd0,   9'd0  },
    '{9'd0, 9'd51,  9'd102, 9'd153, 9'd204, 9'd256, 9'd0,   9'd0,   9'd0  },
    '{9'd0, 9'd42,  9'd85,  9'd128, 9'd170, 9'd213, 9'd256, 9'd0,   9'd0  },
    '{9'd0, 9'd36,  9'd73,  9'd109, 9'd146, 9'd182, 9'd219, 9'd256, 9'd0  },
    '{9'd0, 9'd32,  9'd64,  9'd96,  9'd128, 9'd160, 9'd192, 9'd224, 9'd256}
  };

  function automatic logic [RATIO_W-1:0] ratio_lookup(input logic [COUNT_W-1:0] own,
                                                      input logic [COUNT_W-1:0] total);
    logic [RATIO_W-1:0] r;
    r = '0;
    if (total <= 4'd8 && own <= total) begin
      r = RATIO_LUT[total][own];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/shs_if.sv
// Valid/ready channel interfaces for the cell requests and the result requests.
`default_nettype none

interface shs_cell_if;
  import shs_pkg::*;

  logic  valid;
  logic  ready;
  cell_t cell_state;

  modport source (output valid, output cell_state, input ready);
  modport sink   (input valid, input cell_state, output ready);
endinterface

interface shs_result_if;
  import shs_pkg::*;

  logic               valid;
  logic               ready;
  logic [ROW_W-1:0]   cell_row;
  logic [COL_W-1:0]   cell_col;
  logic               occupied;
  logic               happy;
  logic [COUNT_W-1:0] own_count;
  logic [COUNT_W-1:0] other_count;
  logic [RATIO_W-1:0] ratio_q8;
  logic               frame_last;
  logic [TOTAL_W-1:0] happy_total;
  logic [TOTAL_W-1:0] unhappy_total;
  logic [SUM_W-1:0]   ratio_sum;

  modport source (output valid, output cell_row, output cell_col, output occupied,
                  output happy, output own_count, output other_count, output ratio_q8,
                  output frame_last, output happy_total, output unhappy_total,
                  output ratio_sum, input ready);
  modport sink   (input valid, input cell_row, input cell_col, input occupied,
                  input happy, input own_count, input other_count, input ratio_q8,
                  input frame_last, input happy_total, input unhappy_total,
                  input ratio_sum, output ready);
endinterface

`default_nettype wire

>>> rtl/core/segregation_happiness_stencil_core.sv
// Top level of the segregation happiness stencil: sequencer, line stores and window chain.
// Throughput: one cell request per cycle inside a row unless a held result stalls the window;
// a row's last cell adds a row-closing step, then at frame end cols_in_use + 1 flush steps.
// A window step loads the window chain and the step control, which feed the output register.
// The window chain and the single line store port set the pace: one column enters per step.
// Reset (rst, synchronous, active high) clears the sequencer, position counters, totals and
// both line stores, and loads the configuration reset values; no clearing pass follows.
`default_nettype none

module segregation_happiness_stencil_core #(
  parameter int GRID_WIDTH = shs_pkg::GRID_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  shs_cell_if.sink                         cell_chan,
  shs_result_if.source                     result_chan,
  input  logic                             cfg_write_en,
  input  logic [shs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [shs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import shs_pkg::*;

  localparam int AW = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
  localparam logic [SIZE_W-1:0] COLS_MAX = SIZE_W'(GRID_WIDTH);
  localparam logic [SIZE_W-1:0] ROWS_MAX = SIZE_W'(GRID_HEIGHT);

  // The sequencer runs normal cell steps, the extra step that closes a row, and the
  // flush that walks the final row out of the line stores at the end of a frame.
  typedef enum logic [2:0] {
    ST_RUN   = 3'b001,
    ST_EDGE  = 3'b010,
    ST_FLUSH = 3'b100
  } seq_state_t;

  seq_state_t        state;
  seq_state_t        state_next;

  // Configuration registers and their clamped sizes.
  logic [THR_W-1:0]  threshold;
  logic [SIZE_W-1:0] cols_cfg;
  logic [SIZE_W-1:0] rows_cfg;
  logic [SIZE_W-1:0] cols_eff;
  logic [SIZE_W-1:0] rows_eff;

  // Raster position of the next cell request.
  logic [ROW_W-1:0]  in_row;
  logic [COL_W-1:0]  in_col;
  logic [SIZE_W-1:0] col_plus;
  logic [SIZE_W-1:0] row_plus;
  logic              row_end;
  logic              frame_end;
  cell_t             cell_norm;
  logic              in_fire;

  // Captured at the last cell of a row for the row-closing step and the flush.
  logic [ROW_W-1:0]  edge_row;
  logic [COL_W-1:0]  edge_col;
  logic              edge_frame;
  logic [SIZE_W-1:0] flush_idx;
  logic [SIZE_W-1:0] flush_cols;
  logic              flush_in_range;

  // Line store port.
  logic              store_we;
  logic [AW-1:0]     store_addr;
  cell_t             rd_upper;
  cell_t             rd_lower;

  // Window chain and the step control that travels with it.
  logic              step_go;
  column_t           shift_col;
  column_t           chain_in [WIN_COLS];
  column_t           chain_q  [WIN_COLS];
  step_ctrl_t        step_next;
  step_ctrl_t        s1;
  logic              s1_free;
  logic              res_take_ok;
  logic              res_load;
  logic              res_valid;
  result_t           result;

  // ---------------------------------------------------------------------------
  // Configuration. User writes must arrive only while the block is idle; it is not enforced.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
      cols_cfg  <= COLS_RESET;
      rows_cfg  <= ROWS_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_THRESHOLD: threshold <= cfg_data;
        REG_COLS:      cols_cfg  <= cfg_data[SIZE_W-1:0];
        REG_ROWS:      rows_cfg  <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // A size of zero counts as one; a size beyond the grid is clamped to the grid.
  assign cols_eff = (cols_cfg == '0) ? SIZE_W'(1) :
                    (cols_cfg > COLS_MAX) ? COLS_MAX : cols_cfg;
  assign rows_eff = (rows_cfg == '0) ? SIZE_W'(1) :
                    (rows_cfg > ROWS_MAX) ? ROWS_MAX : rows_cfg;

  // ---------------------------------------------------------------------------
  // Request side. The compare uses >= so that a size shrunk mid-frame still ends
  // the row or the frame at the current position.
  // ---------------------------------------------------------------------------
  assign col_plus  = {1'b0, in_col} + SIZE_W'(1);
  assign row_plus  = {1'b0, in_row} + SIZE_W'(1);
  assign row_end   = (col_plus >= cols_eff);
  assign frame_end = row_end && (row_plus >= rows_eff);

  // The unused fourth code reads as an empty cell.
  assign cell_norm = (cell_chan.cell_state == CELL_FIRST ||
                      cell_chan.cell_state == CELL_SECOND) ? cell_chan.cell_state : CELL_EMPTY;

  // The window stage may step when it holds no result, or when its result moves on
  // into the output register in this cycle.
  assign res_take_ok     = !res_valid || result_chan.ready;
  assign s1_free         = !s1.emit || res_take_ok;
  assign res_load        = s1.emit && res_take_ok;
  assign cell_chan.ready = (state == ST_RUN) && s1_free;
  assign in_fire         = cell_chan.valid && cell_chan.ready;

  assign flush_in_range = (flush_idx < flush_cols);
  assign store_addr     = (state == ST_FLUSH) ? (flush_in_range ? flush_idx[AW-1:0] : '0)
                                              : in_col[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      in_row <= '0;
      in_col <= '0;
    end else if (in_fire) begin
      if (frame_end) begin
        in_row <= '0;
        in_col <= '0;
      end else if (row_end) begin
        in_row <= in_row + ROW_W'(1);
        in_col <= '0;
      end else begin
        in_col <= in_col + COL_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Step generation. A normal step shifts the column of the incoming cell into the
  // window and evaluates the cell one row up and one column left. The row-closing
  // step shifts in an empty column so the last cell of the previous row sits in the
  // centre with no right neighbor. Flush steps shift in the stored columns of the
  // final row with no row below.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    step_go    = 1'b0;
    store_we   = 1'b0;
    shift_col  = '0;
    step_next  = '0;
    case (state)
      ST_RUN: begin
        if (in_fire) begin
          step_go            = 1'b1;
          store_we           = 1'b1;
          shift_col.top      = rd_upper;
          shift_col.mid      = rd_lower;
          shift_col.bot      = cell_norm;
          step_next.emit     = (in_row != '0) && (in_col != '0);
          step_next.row      = in_row - ROW_W'(1);
          step_next.col      = in_col - COL_W'(1);
          step_next.top_ok   = (in_row >= ROW_W'(2));
          step_next.bot_ok   = 1'b1;
          step_next.left_ok  = (in_col >= COL_W'(2));
          step_next.right_ok = 1'b1;
          if (row_end) begin
            state_next = ST_EDGE;
          end
        end
      end
      ST_EDGE: begin
        if (s1_free) begin
          step_go            = 1'b1;
          step_next.emit     = (edge_row != '0);
          step_next.row      = edge_row - ROW_W'(1);
          step_next.col      = edge_col;
          step_next.top_ok   = (edge_row >= ROW_W'(2));
          step_next.bot_ok   = 1'b1;
          step_next.left_ok  = (edge_col != '0);
          step_next.right_ok = 1'b0;
          state_next         = edge_frame ? ST_FLUSH : ST_RUN;
        end
      end
      ST_FLUSH: begin
        if (s1_free) begin
          step_go            = 1'b1;
          if (flush_in_range) begin
            shift_col.top = rd_upper;
            shift_col.mid = rd_lower;
            shift_col.bot = CELL_EMPTY;
          end
          step_next.emit     = (flush_idx != '0);
          step_next.last     = (flush_idx == flush_cols);
          step_next.row      = edge_row;
          step_next.col      = COL_W'(flush_idx - SIZE_W'(1));
          step_next.top_ok   = (edge_row != '0);
          step_next.bot_ok   = 1'b0;
          step_next.left_ok  = (flush_idx >= SIZE_W'(2));
          step_next.right_ok = flush_in_range;
          if (flush_idx == flush_cols) begin
            state_next = ST_RUN;
          end
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && row_end) begin
      edge_row   <= in_row;
      edge_col   <= in_col;
      edge_frame <= frame_end;
      flush_cols <= cols_eff;
    end
    if (state == ST_EDGE && step_go) begin
      flush_idx <= '0;
    end else if (state == ST_FLUSH && step_go) begin
      flush_idx <= flush_idx + SIZE_W'(1);
    end
  end

  // Step control register; it carries the emit flag, so reset clears it.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1 <= '0;
    end else if (s1_free) begin
      s1 <= step_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Line stores and the three-column window chain.
  // ---------------------------------------------------------------------------
  shs_line_store #(
    .DEPTH (GRID_WIDTH),
    .AW    (AW)
  ) u_line_store (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (store_we),
    .addr     (store_addr),
    .wr_cell  (cell_norm),
    .rd_upper (rd_upper),
    .rd_lower (rd_lower)
  );

  // Cell 0 holds the newest (right) column, cell 1 the centre, cell 2 the left one.
  assign chain_in[0] = shift_col;

  for (genvar g = 0; g < WIN_COLS; g++) begin : g_win
    if (g > 0) begin : g_link
      assign chain_in[g] = chain_q[g-1];
    end
    shs_col_cell u_cell (
      .clk      (clk),
      .shift_en (step_go),
      .col_in   (chain_in[g]),
      .col_q    (chain_q[g])
    );
  end

  // ---------------------------------------------------------------------------
  // Evaluation and output register.
  // ---------------------------------------------------------------------------
  shs_result_stage u_result (
    .clk        (clk),
    .rst        (rst),
    .load       (res_load),
    .win_left   (chain_q[2]),
    .win_center (chain_q[1]),
    .win_right  (chain_q[0]),
    .ctrl       (s1),
    .threshold  (threshold),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (result_chan.ready) begin
      res_valid <= 1'b0;
    end
  end

  assign result_chan.valid         = res_valid;
  assign result_chan.cell_row      = result.cell_row;
  assign result_chan.cell_col      = result.cell_col;
  assign result_chan.occupied      = result.occupied;
  assign result_chan.happy         = result.happy;
  assign result_chan.own_count     = result.own_count;
  assign result_chan.other_count   = result.other_count;
  assign result_chan.ratio_q8      = result.ratio_q8;
  assign result_chan.frame_last    = result.frame_last;
  assign result_chan.happy_total   = result.happy_total;
  assign result_chan.unhappy_total = result.unhappy_total;
  assign result_chan.ratio_sum     = result.ratio_sum;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------

  // The flush index never runs past the captured row length.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH) |-> (flush_idx <= flush_cols))
    else $error("flush index beyond row length");

  // The frame-closing step returns the sequencer to normal operation.
  assert property (@(posedge clk) disable iff (rst)
    (s1.emit && s1.last) |-> (state == ST_RUN))
    else $error("frame-closing step without return to run state");

  // Frame totals appear only on the frame-closing result.
  assert property (@(posedge clk) disable iff (rst)
    (result_chan.valid && !result_chan.frame_last) |->
      (result_chan.happy_total == '0 && result_chan.unhappy_total == '0 &&
       result_chan.ratio_sum == '0))
    else $error("frame totals outside the frame-closing result");

  // A cell never has more than eight counted neighbors.
  assert property (@(posedge clk) disable iff (rst)
    result_chan.valid |->
      (({1'b0, result_chan.own_count} + {1'b0, result_chan.other_count}) <= 5'd8))
    else $error("neighbor counts exceed eight");

endmodule

`default_nettype wire

>>> rtl/core/shs_col_cell.sv
// One window column cell: holds a three-row column and passes it to its neighbor on a step.
`default_nettype none

module shs_col_cell (
  input  logic             clk,
  input  logic             shift_en,
  input  shs_pkg::column_t col_in,
  output shs_pkg::column_t col_q
);
  import shs_pkg::*;

  column_t col;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      col <= col_in;
    end
  end

  assign col_q = col;

endmodule

`default_nettype wire

>>> rtl/core/shs_line_store.sv
// Two line stores that hold the previous two rows, one entry per column.
`default_nettype none

module shs_line_store #(
  parameter int DEPTH = shs_pkg::GRID_WIDTH_DEFAULT,
  parameter int AW    = 5
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_en,
  input  logic [AW-1:0]  addr,
  input  shs_pkg::cell_t wr_cell,
  output shs_pkg::cell_t rd_upper,
  output shs_pkg::cell_t rd_lower
);
  import shs_pkg::*;

  cell_t upper [DEPTH];
  cell_t lower [DEPTH];

  // A write ages the column: the lower row moves up and the new cell enters below.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        upper[i] <= CELL_EMPTY;
        lower[i] <= CELL_EMPTY;
      end
    end else if (wr_en) begin
      upper[addr] <= lower[addr];
      lower[addr] <= wr_cell;
    end
  end

  assign rd_upper = upper[addr];
  assign rd_lower = lower[addr];

endmodule

`default_nettype wire

>>> rtl/core/shs_result_stage.sv
// Neighbor counting, ratio and happy decision, frame totals and the result register.
`default_nettype none

module shs_result_stage (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           load,
  input  shs_pkg::column_t               win_left,
  input  shs_pkg::column_t               win_center,
  input  shs_pkg::column_t               win_right,
  input  shs_pkg::step_ctrl_t            ctrl,
  input  logic [shs_pkg::THR_W-1:0]      threshold,
  output shs_pkg::result_t               result
);
  import shs_pkg::*;

  localparam int NB = 8;

  cell_t              centre;
  cell_t              nb      [NB];
  logic [NB-1:0]      nb_ok;
  logic [NB-1:0]      own_hit;
  logic [NB-1:0]      other_hit;
  logic [COUNT_W-1:0] own;
  logic [COUNT_W-1:0] other;
  logic [COUNT_W-1:0] total;
  logic               occupied;
  logic               happy;
  logic [RATIO_W-1:0] ratio;
  logic [12:0]        need;
  logic [12:0]        mine;
  logic [TOTAL_W-1:0] happy_acc;
  logic [TOTAL_W-1:0] unhappy_acc;
  logic [SUM_W-1:0]   ratio_acc;
  logic [TOTAL_W-1:0] happy_acc_next;
  logic [TOTAL_W-1:0] unhappy_acc_next;
  logic [SUM_W-1:0]   ratio_acc_next;

  assign centre   = win_center.mid;
  assign occupied = (centre != CELL_EMPTY);

  always_comb begin
    nb[0] = win_left.top;   nb_ok[0] = ctrl.top_ok & ctrl.left_ok;
    nb[1] = win_center.top; nb_ok[1] = ctrl.top_ok;
    nb[2] = win_right.top;  nb_ok[2] = ctrl.top_ok & ctrl.right_ok;
    nb[3] = win_left.mid;   nb_ok[3] = ctrl.left_ok;
    nb[4] = win_right.mid;  nb_ok[4] = ctrl.right_ok;
    nb[5] = win_left.bot;   nb_ok[5] = ctrl.bot_ok & ctrl.left_ok;
    nb[6] = win_center.bot; nb_ok[6] = ctrl.bot_ok;
    nb[7] = win_right.bot;  nb_ok[7] = ctrl.bot_ok & ctrl.right_ok;
  end

  always_comb begin
    for (int i = 0; i < NB; i++) begin
      own_hit[i]   = occupied && nb_ok[i] && (nb[i] == centre);
      other_hit[i] = occupied && nb_ok[i] && (nb[i] != centre) && (nb[i] != CELL_EMPTY);
    end
  end

  assign own   = COUNT_W'($countones(own_hit));
  assign other = COUNT_W'($countones(other_hit));
  assign total = own + other;

  // Happy when own * 256 >= threshold * total.
  assign need = 13'(threshold) * 13'(total);
  assign mine = 13'({own, 8'd0});

  always_comb begin
    ratio = '0;
    happy = 1'b1;
    if (occupied) begin
      if (total == '0) begin
        ratio = 9'd256;
      end else begin
        ratio = ratio_lookup(own, total);
        happy = (mine >= need);
      end
    end
  end

  assign happy_acc_next   = (occupied && happy)  ? happy_acc + TOTAL_W'(1)   : happy_acc;
  assign unhappy_acc_next = (occupied && !happy) ? unhappy_acc + TOTAL_W'(1) : unhappy_acc;
  assign ratio_acc_next   = ratio_acc + SUM_W'(ratio);

  always_ff @(posedge clk) begin
    if (rst) begin
      happy_acc   <= '0;
      unhappy_acc <= '0;
      ratio_acc   <= '0;
    end else if (load) begin
      if (ctrl.last) begin
        happy_acc   <= '0;
        unhappy_acc <= '0;
        ratio_acc   <= '0;
      end else begin
        happy_acc   <= happy_acc_next;
        unhappy_acc <= unhappy_acc_next;
        ratio_acc   <= ratio_acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.cell_row      <= ctrl.row;
      result.cell_col      <= ctrl.col;
      result.occupied      <= occupied;
      result.happy         <= happy;
      result.own_count     <= own;
      result.other_count   <= other;
      result.ratio_q8      <= ratio;
      result.frame_last    <= ctrl.last;
      result.happy_total   <= ctrl.last ? happy_acc_next : '0;
      result.unhappy_total <= ctrl.last ? unhappy_acc_next : '0;
      result.ratio_sum     <= ctrl.last ? ratio_acc_next : '0;
    end
  end

endmodule

`default_nettype wire
